// ===== src/frpe_pkg.sv =====
// Package for the reduced-precision float round trip block.
// Holds payload structs, register addresses and format constants; no dependencies.
package frpe_pkg;

    localparam int unsigned EXP_BIAS = 127;
    localparam logic [22:0] FRAC_MASK = 23'h7FFFFF;

    localparam logic [0:0] REG_EXP_WIDTH = 1'b0;
    localparam logic [0:0] REG_MAN_WIDTH = 1'b1;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        last_in;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_bits;
        logic        last_out;
    } out_item_t;

    typedef struct packed {
        logic [3:0] exponent_width;
        logic [4:0] mantissa_width;
    } cfg_t;

endpackage

// ===== src/frpe_in_if.sv =====
// Valid/ready channel interfaces for input and result items.
// Depends on frpe_pkg.
interface frpe_in_if;
    logic               valid;
    logic               ready;
    frpe_pkg::in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface frpe_out_if;
    logic                valid;
    logic                ready;
    frpe_pkg::out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== src/frpe_cfg.sv =====
// APB-style register file holding the exponent and mantissa widths.
// Depends on frpe_pkg.
module frpe_cfg (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output frpe_pkg::cfg_t cfg
);
    logic [3:0] exp_w_reg;
    logic [4:0] man_w_reg;
    logic       wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_w_reg <= 4'd8;
            man_w_reg <= 5'd23;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[2])
                frpe_pkg::REG_EXP_WIDTH: exp_w_reg <= pwdata[3:0];
                frpe_pkg::REG_MAN_WIDTH: man_w_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00)
        begin
            case (paddr[2])
                frpe_pkg::REG_EXP_WIDTH: prdata = {28'd0, exp_w_reg};
                frpe_pkg::REG_MAN_WIDTH: prdata = {27'd0, man_w_reg};
                default: prdata = 32'd0;
            endcase
        end
    end

    assign cfg.exponent_width = exp_w_reg;
    assign cfg.mantissa_width = man_w_reg;
endmodule

// ===== src/frpe_conv.sv =====
// Combinational narrow-format squeeze and expand of one single-precision word.
// Depends on frpe_pkg.
module frpe_conv (
    input  frpe_pkg::cfg_t    cfg,
    input  logic [31:0]       value_bits,
    output logic [31:0]       result_bits
);
    logic [3:0]  ew;
    logic [4:0]  mw;
    logic [7:0]  lim;
    logic [7:0]  bexp;
    logic [8:0]  lo_sum;
    logic [8:0]  hi_lim;
    logic [22:0] keep_mask;

    always_comb
    begin
        ew = cfg.exponent_width;
        if (ew < 4'd2) ew = 4'd2;
        if (ew > 4'd8) ew = 4'd8;
        mw = (cfg.mantissa_width > 5'd23) ? 5'd23 : cfg.mantissa_width;
        lim = 8'((9'd1 << (ew - 4'd1)) - 9'd1);
        bexp = value_bits[30:23];
        lo_sum = {1'b0, bexp} + {1'b0, lim};
        hi_lim = 9'(frpe_pkg::EXP_BIAS) + {1'b0, lim};
        keep_mask = frpe_pkg::FRAC_MASK & ~23'((24'd1 << (5'd23 - mw)) - 24'd1);
        if (lo_sum < 9'(frpe_pkg::EXP_BIAS))
            result_bits = 32'd0;
        else if ({1'b0, bexp} > hi_lim)
            result_bits = {value_bits[31], hi_lim[7:0], keep_mask};
        else
            result_bits = {value_bits[31], bexp, value_bits[22:0] & keep_mask};
    end
endmodule

// ===== src/float32_reduced_precision_emulate.sv =====
// Reduced-precision float round trip: each single-precision item is squeezed into a
// narrow float (sign, exponent of exponent_width bits, mantissa_width
// fraction bits, truncated) and expanded again. Underflow gives +0.0; overflow, Inf and
// NaN saturate to the largest magnitude. One item per cycle unless the result side stalls.
// The path is an input register, one pass of conversion logic, and a result register
// with a skid stage so input is taken while a result waits. Registers: 0x0 exponent_width,
// 0x4 mantissa_width. Depends on frpe_pkg, frpe_in_if, frpe_cfg, frpe_conv.
module float32_reduced_precision_emulate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    frpe_in_if.sink     in_ch,
    frpe_out_if.source  out_ch
);
    frpe_pkg::cfg_t      cfg;
    frpe_pkg::in_item_t  s1_reg;
    logic                s1_vld_reg;
    frpe_pkg::out_item_t out_reg, skid_reg, conv_item;
    logic                out_vld_reg, skid_vld_reg;
    logic                s1_adv;

    frpe_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    frpe_conv u_conv (
        .cfg(cfg),
        .value_bits(s1_reg.value_bits),
        .result_bits(conv_item.result_bits)
    );
    assign conv_item.last_out = s1_reg.last_in;

    // stage 1 drains when the skid slot is free
    assign s1_adv = !skid_vld_reg;
    assign in_ch.ready = !s1_vld_reg || s1_adv;
    assign out_ch.valid = out_vld_reg;
    assign out_ch.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_vld_reg <= in_ch.valid;
            if (!out_vld_reg || out_ch.ready)
            begin
                if (skid_vld_reg)
                begin
                    out_vld_reg <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
                else
                    out_vld_reg <= s1_vld_reg;
            end
            else if (s1_vld_reg && s1_adv)
                skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            s1_reg <= in_ch.payload;
        if (!out_vld_reg || out_ch.ready)
            out_reg <= skid_vld_reg ? skid_reg : conv_item;
        else if (s1_vld_reg && s1_adv)
            skid_reg <= conv_item;
    end
endmodule

// ===== tb/frpe_tb_if.sv =====
`timescale 1ns / 1ps
// Testbench-side note: the channel interfaces come from the RTL (frpe_in_if, frpe_out_if).
// This file holds a small helper package of test constants; depends on frpe_pkg.
package frpe_tb_pkg;
    localparam logic [2:0] ADDR_EXP_WIDTH = {frpe_pkg::REG_EXP_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_MAN_WIDTH = {frpe_pkg::REG_MAN_WIDTH, 2'b00};
endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for float32_reduced_precision_emulate: drives random and directed items,
// predicts each result from a local copy of the register settings and checks them in order.
// Depends on frpe_pkg, frpe_tb_pkg, frpe_in_if, frpe_out_if and the RTL.
module testbench;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frpe_in_if  in_ch ();
    frpe_out_if out_ch ();

    float32_reduced_precision_emulate u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    logic [3:0]           exp_width_reg;
    logic [4:0]           man_width_reg;
    frpe_pkg::out_item_t  expected_q[$];
    int                   error_count;
    int                   idle_cycles;
    int                   sent_count;
    int                   checked_count;
    int                   ready_mode;
    int                   hold_cycles;

    localparam int IDLE_LIMIT = 5000;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Narrow-format round trip of one single-precision word.
    function automatic logic [31:0] narrow_round_trip(logic [31:0] w);
        int unsigned ew;
        int unsigned mw;
        int unsigned lim;
        int unsigned bexp;
        logic [22:0] keep;
        ew = exp_width_reg;
        mw = man_width_reg;
        if (ew < 2) ew = 2;
        if (ew > 8) ew = 8;
        if (mw > 23) mw = 23;
        lim = (1 << (ew - 1)) - 1;
        bexp = w[30:23];
        keep = frpe_pkg::FRAC_MASK & ~((23'd1 << (23 - mw)) - 23'd1);
        if (bexp + lim < frpe_pkg::EXP_BIAS)
            return 32'h0;
        else if (bexp > frpe_pkg::EXP_BIAS + lim)
            return {w[31], 8'(frpe_pkg::EXP_BIAS + lim), keep};
        else
            return {w[31], w[30:23], w[22:0] & keep};
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_item(logic [31:0] value, logic last);
        int g;
        frpe_pkg::out_item_t exp_item;
        g = gap_len();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= '{value_bits: value, last_in: last};
        exp_item.result_bits = narrow_round_trip(value);
        exp_item.last_out = last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        expected_q.push_back(exp_item);
        sent_count++;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == frpe_tb_pkg::ADDR_EXP_WIDTH) exp_width_reg = data[3:0];
        else                                     man_width_reg = data[4:0];
    endtask

    task automatic set_format(int ew, int mw);
        drain_results();
        write_reg(frpe_tb_pkg::ADDR_EXP_WIDTH, ew);
        @(posedge clk);
        write_reg(frpe_tb_pkg::ADDR_MAN_WIDTH, mw);
    endtask

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 5))
            0: w[30:23] = 8'd127 + 8'($urandom_range(0, 16)) - 8'd8;
            1: w[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: w[30:23] = 8'd127 + 8'($urandom_range(0, 260)) - 8'd130;
            default: ;
        endcase
        return w;
    endfunction

    task automatic test_directed();
        logic [31:0] words[$];
        words = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
                  32'h3F80_0000, 32'hBF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
                  32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF,
                  32'h0080_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h3E00_0000};
        foreach (words[i]) send_item(words[i], i[0]);
        set_format(2, 0);
        foreach (words[i]) send_item(words[i], ~i[0]);
        // out-of-range register values clamp
        set_format(0, 31);
        send_item(32'h3FAA_AAAA, 1'b1);
        send_item(32'h4000_0001, 1'b0);
        set_format(15, 24);
        send_item(32'h0055_5555, 1'b1);
        send_item(32'hFF80_0000, 1'b0);
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 12; phase++)
        begin
            set_format($urandom_range(0, 15), $urandom_range(0, 31));
            ready_mode = phase % 3;
            for (int i = 0; i < 105; i++)
                send_item(rand_word(), $urandom_range(0, 1));
        end
    endtask

    task automatic test_back_to_back();
        frpe_pkg::out_item_t exp_item;
        set_format(5, 10);
        ready_mode = 2;
        for (int i = 0; i < 60; i++)
        begin
            in_ch.valid   <= 1'b1;
            in_ch.payload <= '{value_bits: rand_word(), last_in: i[0]};
            @(posedge clk);
            while (!in_ch.ready) @(posedge clk);
            exp_item.result_bits = narrow_round_trip(in_ch.payload.value_bits);
            exp_item.last_out = in_ch.payload.last_in;
            expected_q.push_back(exp_item);
            sent_count++;
        end
    endtask

    // Result sink: random back-pressure, occasional long stalls (not in mode 2), ordered compare.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (ready_mode == 2)
                out_ch.ready <= 1'b1;
            else if (hold_cycles > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else if ($urandom_range(0, 99) < 2)
            begin
                out_ch.ready <= 1'b0;
                hold_cycles <= $urandom_range(8, 40);
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) < (ready_mode == 0 ? 85 : 40));
        end
    end

    always @(posedge clk)
    begin
        frpe_pkg::out_item_t exp_item;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %h/%b", $time,
                         out_ch.payload.result_bits, out_ch.payload.last_out);
                error_count++;
            end
            else
            begin
                exp_item = expected_q.pop_front();
                checked_count++;
                if (out_ch.payload.result_bits !== exp_item.result_bits)
                begin
                    $display("%0t: result_bits expected %h actual %h", $time,
                             exp_item.result_bits, out_ch.payload.result_bits);
                    error_count++;
                end
                if (out_ch.payload.last_out !== exp_item.last_out)
                begin
                    $display("%0t: last_out expected %b actual %b", $time,
                             exp_item.last_out, out_ch.payload.last_out);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        ready_mode = 0;
        hold_cycles = 0;
        error_count = 0;
        idle_cycles = 0;
        sent_count = 0;
        checked_count = 0;
        exp_width_reg = 4'd8;
        man_width_reg = 5'd23;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_back_to_back();
        drain_results();
        $display("Covered %0d items over many exponent/mantissa widths, clamped register",
                 sent_count);
        $display("values, specials (zero, subnormal, Inf, NaN) and back-pressure; %0d checked.",
                 checked_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
